>>> rtl/lkvc_pkg.sv
// Package with the shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_CAPACITY_RESET = 5'd16;

    typedef enum logic {
        FUNC_LOOKUP = 1'b0,
        FUNC_WRITE  = 1'b1
    } t_func;

    typedef struct packed {
        logic hit;
        logic val_we;
        logic val_re;
    } t_dir_status;

endpackage

>>> rtl/lkvc_if.sv
// Valid/ready channel interfaces for requests and responses of the cache.
`timescale 1ns / 1ps

interface lkvc_req_if import lkvc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_func                    func;
    logic signed [KEY_W-1:0]  key;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [VAL_W-1:0]  read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

>>> rtl/lkvc_dir.sv
// Directory of the cache: keys, valid bits, recency ranks and fill count.
`timescale 1ns / 1ps

module lkvc_dir import lkvc_pkg::*; #(
    parameter int ENTRIES = 16,
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_go,
    input  t_func                   i_func,
    input  logic [KEY_W-1:0]        i_key,
    input  logic [CFG_W-1:0]        i_capacity,
    output t_dir_status             o_status,
    output logic [SLOT_W-1:0]       o_slot
);

    localparam int RANK_W = SLOT_W;
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [KEY_W-1:0]   r_keys [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [RANK_W-1:0]  r_rank [ENTRIES];
    logic [CNT_W-1:0]   r_count;

    logic [ENTRIES-1:0] n_valid;
    logic [RANK_W-1:0]  n_rank [ENTRIES];
    logic [CNT_W-1:0]   n_count;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [ENTRIES-1:0] valid_left;
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic [RANK_W-1:0]  hit_rank;
    logic [RANK_W-1:0]  old_rank;
    logic               full;
    logic               evict;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic               insert;

    always_comb begin
        match    = '0;
        hit_idx  = '0;
        hit_rank = '0;
        victim   = '0;
        old_rank = RANK_W'(r_count - CNT_W'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_keys[i] == i_key);
            victim[i] = r_valid[i] && (r_rank[i] == old_rank);
            if (match[i]) begin
                hit_idx  = hit_idx | SLOT_W'(i);
                hit_rank = hit_rank | r_rank[i];
            end
        end
        hit = |match;
    end

    always_comb begin
        full = (r_count >= CNT_W'(ENTRIES))
            || ((i_capacity != '0) && (CMP_W'(r_count) >= CMP_W'(i_capacity)))
            || ((i_capacity == '0) && (r_count != '0));
        evict      = full && (r_count != '0);
        valid_left = evict ? (r_valid & ~victim) : r_valid;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_left[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
        insert = i_go && (i_func == FUNC_WRITE) && !hit && free_found;
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;
        if (i_go && hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
            n_rank[hit_idx] = '0;
        end else if (i_go && (i_func == FUNC_WRITE) && free_found) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_left[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
            n_valid           = valid_left;
            n_valid[free_idx] = 1'b1;
            n_rank[free_idx]  = '0;
            n_count           = evict ? r_count : r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (insert) begin
            r_keys[free_idx] <= i_key;
        end
    end

    assign o_slot          = ((i_func == FUNC_WRITE) && !hit) ? free_idx : hit_idx;
    assign o_status.hit    = hit;
    assign o_status.val_we = i_go && (i_func == FUNC_WRITE) && (hit || free_found);
    assign o_status.val_re = i_go && (i_func == FUNC_LOOKUP);

endmodule

>>> rtl/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
`timescale 1ns / 1ps
//
// Requests arrive on i_req (func, key, value) and lookups answer on o_rsp
// (hit, read_value). A transfer happens when valid and ready are both high.
// A lookup that hits returns the stored value and makes the entry the most
// recent; a miss returns all ones with hit clear. Writes update or insert
// and give no response; a full cache evicts its least recent entry.
// The capacity register is loaded from i_cfg_wdata when i_cfg_we is high.
// An accepted request is held in an input register, where the key compare,
// rank update and replacement are done, and the response lands in the output
// register: a lookup passes from the input register into the output register
// when the output register is free. One request is taken every cycle while
// no lookup waits for the output register; the single pass over the directory
// between the input and output registers sets that figure.
// When the receiver stalls with a response waiting, writes keep flowing and
// a lookup waits in the input register until the response is taken.
// Synchronous reset empties the cache and sets the capacity to 16.
//
module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    lkvc_req_if.sink          i_req,
    lkvc_rsp_if.source        o_rsp
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [CFG_W-1:0]  r_capacity;
    logic              r_in_valid;
    t_func             r_in_func;
    logic [KEY_W-1:0]  r_in_key;
    logic [VAL_W-1:0]  r_in_value;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [VAL_W-1:0]  r_out_data;
    logic [VAL_W-1:0]  r_values [ENTRIES];

    logic              go;
    t_dir_status       status;
    logic [SLOT_W-1:0] slot;

    assign go = r_in_valid
             && ((r_in_func == FUNC_WRITE) || !r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CFG_CAPACITY_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_in_valid <= i_req.valid || (r_in_valid && !go);
            if (status.val_re) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_func  <= i_req.func;
            r_in_key   <= i_req.key;
            r_in_value <= i_req.value;
        end
    end

    lkvc_dir #(
        .ENTRIES (ENTRIES)
    ) u_dir (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_func     (r_in_func),
        .i_key      (r_in_key),
        .i_capacity (r_capacity),
        .o_status   (status),
        .o_slot     (slot)
    );

    always_ff @(posedge i_clk) begin
        if (status.val_we) begin
            r_values[slot] <= r_in_value;
        end
        if (status.val_re) begin
            r_out_hit  <= status.hit;
            r_out_data <= status.hit ? r_values[slot] : '1;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_data;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the LRU key-value cache: directed table, random traffic, checker.
`timescale 1ns / 1ps

module tb_top import lkvc_pkg::*; ();

    localparam int ENTRIES = 16;
    localparam int POOL_MAX = 24;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int N_DIRECTED = 24;

    typedef enum bit {
        ROW_REQUEST,
        ROW_CAPACITY
    } t_row_kind;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_lookup_rsp;

    typedef struct {
        t_row_kind        kind;
        t_func            func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CFG_W-1:0] capacity;
        bit               typed;
        logic             exp_hit;
        logic [VAL_W-1:0] exp_value;
    } t_directed_row;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lkvc_req_if req_if ();
    lkvc_rsp_if rsp_if ();

    lru_key_value_cache #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Shadow copy of the cache contents and capacity.
    logic [KEY_W-1:0] shadow_key [ENTRIES];
    logic [VAL_W-1:0] shadow_value [ENTRIES];
    bit               shadow_used [ENTRIES];
    bit [3:0]         shadow_age [ENTRIES];
    int unsigned      shadow_fill;
    logic [CFG_W-1:0] shadow_capacity;

    t_lookup_rsp      expected_lookups [$];
    int               fail_count = 0;
    int               req_gap_pct;
    int               rsp_stall_pct;
    int               stall_left;

    logic             row_typed;
    logic             row_exp_hit;
    logic [VAL_W-1:0] row_exp_value;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h0000_0000, 32'h1234_5678, 5'd0, 1'b1, 1'b0, 32'hFFFF_FFFF},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'hFFFF_FFFF},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0, 32'hFFFF_FFFF},
        '{ROW_REQUEST, FUNC_WRITE,  32'h7FFF_FFFF, 32'h8000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h8000_0000},
        '{ROW_REQUEST, FUNC_WRITE,  32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_WRITE,  32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_REQUEST, FUNC_WRITE,  32'h7FFF_FFFF, 32'h0000_0001, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h0000_0001},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_CAPACITY, FUNC_LOOKUP, 32'h0, 32'h0, 5'd2, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_WRITE,  32'h0000_0005, 32'h0000_0005, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h0000_0005, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_CAPACITY, FUNC_LOOKUP, 32'h0, 32'h0, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_WRITE,  32'h0000_0006, 32'h0000_0006, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h0000_0006, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_CAPACITY, FUNC_LOOKUP, 32'h0, 32'h0, 5'd31, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_WRITE,  32'hAAAA_AAAA, 32'h5555_5555, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_WRITE,  32'h5555_5555, 32'hAAAA_AAAA, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_REQUEST, FUNC_LOOKUP, 32'h5555_5555, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0}
    };

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void flag_failure(string what, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endfunction

    function automatic void promote_slot(int s);
        bit [3:0] r;
        r = shadow_age[s];
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_used[i] && shadow_age[i] < r) begin
                shadow_age[i]++;
            end
        end
        shadow_age[s] = 4'd0;
    endfunction

    // Applies one request to the shadow cache; returns 1 when a response is due.
    function automatic bit cache_access(t_func f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                        output t_lookup_rsp rsp);
        int          s;
        int          victim;
        int unsigned limit;
        s = -1;
        rsp = '{1'b0, '1};
        for (int i = 0; i < ENTRIES; i++) begin
            if (s < 0 && shadow_used[i] && shadow_key[i] == k) begin
                s = i;
            end
        end
        if (f == FUNC_LOOKUP) begin
            if (s >= 0) begin
                promote_slot(s);
                rsp = '{1'b1, shadow_value[s]};
            end
            return 1'b1;
        end
        if (s >= 0) begin
            shadow_value[s] = v;
            promote_slot(s);
            return 1'b0;
        end
        limit = (shadow_capacity == 0) ? 1 : (shadow_capacity > ENTRIES) ? ENTRIES
                                                                         : shadow_capacity;
        if (shadow_fill >= limit) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (shadow_used[i] && (victim < 0 || shadow_age[i] >= shadow_age[victim])) begin
                    victim = i;
                end
            end
            if (victim >= 0) begin
                shadow_used[victim] = 1'b0;
                shadow_age[victim] = 4'd0;
                shadow_fill--;
            end
        end
        s = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (s < 0 && !shadow_used[i]) begin
                s = i;
            end
        end
        if (s < 0) begin
            return 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_used[i]) begin
                shadow_age[i]++;
            end
        end
        shadow_key[s] = k;
        shadow_value[s] = v;
        shadow_used[s] = 1'b1;
        shadow_age[s] = 4'd0;
        shadow_fill++;
        return 1'b0;
    endfunction

    // Response checking, shadow update on each request transfer and capacity write, and receiver stalls.
    always @(posedge clk) begin
        t_lookup_rsp got;
        t_lookup_rsp want;
        bit          has_rsp;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                shadow_used[i] = 1'b0;
                shadow_age[i] = 4'd0;
                shadow_key[i] = '0;
                shadow_value[i] = '0;
            end
            shadow_fill = 0;
            shadow_capacity = CFG_CAPACITY_RESET;
            stall_left = 0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.hit, rsp_if.read_value};
                if (expected_lookups.size() == 0) begin
                    flag_failure("response with none expected", 'x, got.read_value);
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit) begin
                        flag_failure("hit", 32'(want.hit), 32'(got.hit));
                    end
                    if (got.read_value !== want.read_value) begin
                        flag_failure("read_value", want.read_value, got.read_value);
                    end
                end
            end
            if (cfg_we) begin
                shadow_capacity = cfg_wdata;
            end
            if (req_if.valid && req_if.ready) begin
                has_rsp = cache_access(req_if.func, req_if.key, req_if.value, want);
                if (has_rsp) begin
                    expected_lookups.push_back(row_typed ? t_lookup_rsp'{row_exp_hit, row_exp_value}
                                                         : want);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
                stall_left = $urandom_range(0, 2);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(t_func f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                logic typed, logic eh, logic [VAL_W-1:0] ev);
        int gap;
        if ($urandom_range(0, 99) < req_gap_pct) begin
            gap = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= f;
        req_if.key <= k;
        req_if.value <= v;
        row_typed <= typed;
        row_exp_hit <= eh;
        row_exp_value <= ev;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic drain_lookups();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_lookups.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] c);
        drain_lookups();
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] capacity;
        logic [KEY_W-1:0] key_pool [POOL_MAX];
        logic [KEY_W-1:0] key;
        int               limit;
        int               pool_size;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_if.valid <= 1'b0;
        req_if.func <= FUNC_LOOKUP;
        req_if.key <= '0;
        req_if.value <= '0;
        row_typed <= 1'b0;
        row_exp_hit <= 1'b0;
        row_exp_value <= '0;
        req_gap_pct = 20;
        rsp_stall_pct = 20;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CAPACITY) begin
                write_capacity(directed_rows[i].capacity);
            end else begin
                send_request(directed_rows[i].func, directed_rows[i].key, directed_rows[i].value,
                             directed_rows[i].typed, directed_rows[i].exp_hit,
                             directed_rows[i].exp_value);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: capacity = 5'd16;
                1: capacity = 5'd1;
                2: capacity = 5'd31;
                3: capacity = 5'd0;
                4: capacity = 5'd17;
                5: capacity = 5'd4;
                default: capacity = CFG_W'($urandom_range(0, 31));
            endcase
            write_capacity(capacity);
            limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
            pool_size = limit + $urandom_range(1, 6);
            if (pool_size > POOL_MAX) begin
                pool_size = POOL_MAX;
            end
            for (int i = 0; i < POOL_MAX; i++) begin
                case ($urandom_range(0, 9))
                    0: key_pool[i] = 32'h8000_0000;
                    1: key_pool[i] = 32'h7FFF_FFFF;
                    2: key_pool[i] = 32'hFFFF_FFFF;
                    default: key_pool[i] = $urandom;
                endcase
            end
            if (phase == PHASES - 1) begin
                req_gap_pct = 0;
                rsp_stall_pct = 0;
            end else begin
                req_gap_pct = $urandom_range(0, 2) * 15;
                rsp_stall_pct = $urandom_range(0, 2) * 15;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                key = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
                send_request(t_func'($urandom_range(0, 1)), key, $urandom, 1'b0, 1'b0, '0);
            end
        end

        drain_lookups();
        if (fail_count == 0) begin
            $display("lru_key_value_cache regression: pass");
        end else begin
            $display("lru_key_value_cache regression: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("lru_key_value_cache regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/lkvc_pkg.sv
rtl/lkvc_if.sv
rtl/lkvc_dir.sv
rtl/lru_key_value_cache.sv
tb/tb_top.sv
